>>> hw/rtl/touchpad_gesture_classifier_macros.svh
// Assertion macros for the touchpad gesture classifier checker.
// No dependencies; taken in by the checker with `include.
`ifndef TOUCHPAD_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCHPAD_GESTURE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TGC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("touchpad gesture classifier: check failed");

// Next-cycle implication, disabled during reset.
`define TGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("touchpad gesture classifier: check failed");

`endif

>>> hw/rtl/tgc_pkg.sv
// Package for the touchpad gesture classifier: field widths, event and
// register codes, reset values and shared structs. No dependencies.
package tgc_pkg;

    localparam int ACC_WIDTH_DEF = 24;

    localparam int FUNC_W      = 3;
    localparam int FINGER_W    = 4;
    localparam int DELTA_W     = 16;
    localparam int SCALE_W     = 16;
    localparam int SWIPE_THR_W = 20;
    localparam int PINCH_THR_W = 16;
    localparam int MASK_W      = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int GFING_W     = 3;
    localparam int GDIR_W      = 2;
    localparam int GIDX_W      = 4;

    // event kinds
    localparam logic [FUNC_W-1:0] FUNC_SWIPE_BEGIN  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SWIPE_UPDATE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SWIPE_END    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PINCH_BEGIN  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PINCH_UPDATE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_PINCH_END    = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PINCH_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd2;

    localparam logic [SWIPE_THR_W-1:0] SWIPE_THR_RST = 20'd640;
    localparam logic [PINCH_THR_W-1:0] PINCH_THR_RST = 16'd614;
    localparam logic [MASK_W-1:0]      ENABLE_RST    = 12'hFFF;
    localparam logic [SCALE_W-1:0]     SCALE_ONE     = 16'd4096;

    localparam logic [FINGER_W-1:0] FINGERS_THREE = 4'd3;
    localparam logic [FINGER_W-1:0] FINGERS_FOUR  = 4'd4;

    localparam logic KIND_SWIPE = 1'b0;
    localparam logic KIND_PINCH = 1'b1;

    // gesture directions
    localparam logic [GDIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [GDIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [GDIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [GDIR_W-1:0] DIR_RIGHT = 2'd3;
    localparam logic [GDIR_W-1:0] DIR_IN    = 2'd0;
    localparam logic [GDIR_W-1:0] DIR_OUT   = 2'd1;

    typedef struct packed {
        logic [SWIPE_THR_W-1:0] swipe_thr;
        logic [PINCH_THR_W-1:0] pinch_thr;
        logic [MASK_W-1:0]      enable;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [FINGER_W-1:0]       finger_count;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic [SCALE_W-1:0]        pinch_scale;
    } event_t;

    typedef struct packed {
        logic               hit;
        logic               kind;
        logic [GFING_W-1:0] fingers;
        logic [GDIR_W-1:0]  direction;
        logic [GIDX_W-1:0]  index;
    } gesture_t;

endpackage

>>> hw/rtl/tgc_if.sv
// Channel interfaces of the touchpad gesture classifier: events in,
// gestures out, register writes. Depends on tgc_pkg.
interface tgc_event_if;
    logic                                  valid;
    logic                                  ready;
    logic [tgc_pkg::FUNC_W-1:0]            func;
    logic [tgc_pkg::FINGER_W-1:0]          finger_count;
    logic signed [tgc_pkg::DELTA_W-1:0]    delta_x;
    logic signed [tgc_pkg::DELTA_W-1:0]    delta_y;
    logic [tgc_pkg::SCALE_W-1:0]           pinch_scale;

    modport source (output valid, func, finger_count, delta_x, delta_y, pinch_scale,
                    input ready);
    modport sink   (input valid, func, finger_count, delta_x, delta_y, pinch_scale,
                    output ready);
endinterface

interface tgc_gesture_if;
    logic                          valid;
    logic                          ready;
    logic                          gesture_kind;
    logic [tgc_pkg::GFING_W-1:0]   gesture_fingers;
    logic [tgc_pkg::GDIR_W-1:0]    gesture_direction;
    logic [tgc_pkg::GIDX_W-1:0]    gesture_index;

    modport source (output valid, gesture_kind, gesture_fingers, gesture_direction,
                    gesture_index, input ready);
    modport sink   (input valid, gesture_kind, gesture_fingers, gesture_direction,
                    gesture_index, output ready);
endinterface

interface tgc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tgc_pkg::CFG_IDX_W-1:0]    index;
    logic [tgc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/touchpad_gesture_classifier.sv
// Touchpad gesture classifier top level: event register, gesture state,
// classifier and result register. Depends on tgc_pkg, tgc_if, tgc_classify.
//
//  port     dir  interface        contents
//  evt      in   tgc_event_if     func, finger_count, delta_x, delta_y, pinch_scale
//  gesture  out  tgc_gesture_if   gesture_kind, gesture_fingers, gesture_direction,
//                                 gesture_index
//  cfg      in   tgc_cfg_if       index, data (0 swipe thr, 1 pinch thr, 2 enable)
//
// One event per cycle sustained unless a stalled word holds the event register.
// An accepted event sits in the event register, then updates the state and (for
// an end event) loads the result register; the gesture word is visible from then on.
// rst_n clears control state, the accumulators, the held finger count, the
// latched scale and the registers to their reset values.
// A stalled gesture word holds the event register only when the next event
// also produces a word; other events keep flowing. cfg is always ready.
module touchpad_gesture_classifier #(
    parameter int ACC_WIDTH = tgc_pkg::ACC_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    tgc_event_if.sink              evt,
    tgc_gesture_if.source          gesture,
    tgc_cfg_if.sink                cfg
);
    localparam int SumW = ACC_WIDTH + 1;

    tgc_pkg::cfg_t       cfg_reg;
    tgc_pkg::event_t     evt_reg;
    logic                evt_valid_reg;
    logic signed [ACC_WIDTH-1:0] sum_x_reg, sum_x_next;
    logic signed [ACC_WIDTH-1:0] sum_y_reg, sum_y_next;
    logic [tgc_pkg::SCALE_W-1:0]  scale_reg, scale_next;
    logic [tgc_pkg::FINGER_W-1:0] fingers_reg, fingers_next;
    tgc_pkg::gesture_t   res_reg;
    logic                res_valid_reg;

    tgc_pkg::gesture_t   cls;
    logic                swipe_end;
    logic                pinch_end;
    logic                advance;
    logic                evt_take;
    logic signed [SumW-1:0] add_x;
    logic signed [SumW-1:0] add_y;

    // saturate a widened sum back to the accumulator range
    function automatic logic signed [ACC_WIDTH-1:0] sat(input logic signed [SumW-1:0] v);
        logic signed [ACC_WIDTH-1:0] r;
        if (v[SumW-1] != v[SumW-2])
            r = v[SumW-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        else
            r = v[ACC_WIDTH-1:0];
        return r;
    endfunction

    // ---- register port ----
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swipe_thr <= tgc_pkg::SWIPE_THR_RST;
            cfg_reg.pinch_thr <= tgc_pkg::PINCH_THR_RST;
            cfg_reg.enable    <= tgc_pkg::ENABLE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tgc_pkg::REG_SWIPE_THR: cfg_reg.swipe_thr <= cfg.data;
                tgc_pkg::REG_PINCH_THR:
                    cfg_reg.pinch_thr <= cfg.data[tgc_pkg::PINCH_THR_W-1:0];
                tgc_pkg::REG_ENABLE:
                    cfg_reg.enable <= cfg.data[tgc_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- classification of the registered event ----
    assign swipe_end = evt_reg.func == tgc_pkg::FUNC_SWIPE_END;
    assign pinch_end = evt_reg.func == tgc_pkg::FUNC_PINCH_END;

    tgc_classify #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_classify (
        .swipe_end    (swipe_end),
        .pinch_end    (pinch_end),
        .sum_x        (sum_x_reg),
        .sum_y        (sum_y_reg),
        .last_scale   (scale_reg),
        .held_fingers (fingers_reg),
        .cfg          (cfg_reg),
        .gesture      (cls)
    );

    // event leaves the register unless it has a word and the slot is full
    assign advance  = evt_valid_reg && (!cls.hit || !res_valid_reg || gesture.ready);
    assign evt.ready = !evt_valid_reg || advance;
    assign evt_take  = evt.valid && evt.ready;

    assign add_x = SumW'(sum_x_reg) + SumW'(evt_reg.delta_x);
    assign add_y = SumW'(sum_y_reg) + SumW'(evt_reg.delta_y);

    always_comb
    begin
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        scale_next   = scale_reg;
        fingers_next = fingers_reg;
        case (evt_reg.func)
            tgc_pkg::FUNC_SWIPE_BEGIN:
            begin
                sum_x_next   = '0;
                sum_y_next   = '0;
                fingers_next = evt_reg.finger_count;
            end
            tgc_pkg::FUNC_SWIPE_UPDATE:
            begin
                sum_x_next = sat(add_x);
                sum_y_next = sat(add_y);
            end
            tgc_pkg::FUNC_PINCH_BEGIN:
            begin
                scale_next   = tgc_pkg::SCALE_ONE;
                fingers_next = evt_reg.finger_count;
            end
            tgc_pkg::FUNC_PINCH_UPDATE: scale_next = evt_reg.pinch_scale;
            tgc_pkg::FUNC_SWIPE_END,
            tgc_pkg::FUNC_PINCH_END:    fingers_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            scale_reg     <= tgc_pkg::SCALE_ONE;
            fingers_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
                evt_valid_reg <= evt.valid;
            if (advance)
            begin
                sum_x_reg   <= sum_x_next;
                sum_y_reg   <= sum_y_next;
                scale_reg   <= scale_next;
                fingers_reg <= fingers_next;
            end
            if (advance && cls.hit)
                res_valid_reg <= 1'b1;
            else if (gesture.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            evt_reg.func         <= evt.func;
            evt_reg.finger_count <= evt.finger_count;
            evt_reg.delta_x      <= evt.delta_x;
            evt_reg.delta_y      <= evt.delta_y;
            evt_reg.pinch_scale  <= evt.pinch_scale;
        end
        if (advance && cls.hit)
            res_reg <= cls;
    end

    assign gesture.valid             = res_valid_reg;
    assign gesture.gesture_kind      = res_reg.kind;
    assign gesture.gesture_fingers   = res_reg.fingers;
    assign gesture.gesture_direction = res_reg.direction;
    assign gesture.gesture_index     = res_reg.index;

endmodule

>>> hw/rtl/tgc_classify.sv
// End-event classifier: thresholds, dominant axis, index and enable test.
// Depends on tgc_pkg.
module tgc_classify #(
    parameter int ACC_WIDTH = tgc_pkg::ACC_WIDTH_DEF
) (
    input  logic                              swipe_end,
    input  logic                              pinch_end,
    input  logic signed [ACC_WIDTH-1:0]       sum_x,
    input  logic signed [ACC_WIDTH-1:0]       sum_y,
    input  logic [tgc_pkg::SCALE_W-1:0]       last_scale,
    input  logic [tgc_pkg::FINGER_W-1:0]      held_fingers,
    input  tgc_pkg::cfg_t                     cfg,
    output tgc_pkg::gesture_t                 gesture
);
    localparam int CmpW = (ACC_WIDTH > tgc_pkg::SWIPE_THR_W) ? ACC_WIDTH
                                                             : tgc_pkg::SWIPE_THR_W;
    localparam int DW = tgc_pkg::SCALE_W + 1;

    logic                          fingers_ok;
    logic                          four;
    logic [ACC_WIDTH-1:0]          ax;
    logic [ACC_WIDTH-1:0]          ay;
    logic [CmpW-1:0]               ax_e;
    logic [CmpW-1:0]               ay_e;
    logic [CmpW-1:0]               thr_e;
    logic                          swipe_ok;
    logic [tgc_pkg::GDIR_W-1:0]    swipe_dir;
    logic signed [DW-1:0]          dev;
    logic [DW-1:0]                 adev;
    logic                          pinch_ok;
    logic [tgc_pkg::GIDX_W-1:0]    idx;
    logic [tgc_pkg::GDIR_W-1:0]    dir;

    assign fingers_ok = (held_fingers == tgc_pkg::FINGERS_THREE) ||
                        (held_fingers == tgc_pkg::FINGERS_FOUR);
    assign four = (held_fingers == tgc_pkg::FINGERS_FOUR);

    // magnitude of the most negative sum still fits unsigned
    assign ax    = sum_x[ACC_WIDTH-1] ? ACC_WIDTH'(-sum_x) : ACC_WIDTH'(sum_x);
    assign ay    = sum_y[ACC_WIDTH-1] ? ACC_WIDTH'(-sum_y) : ACC_WIDTH'(sum_y);
    assign ax_e  = CmpW'(ax);
    assign ay_e  = CmpW'(ay);
    assign thr_e = CmpW'(cfg.swipe_thr);
    assign swipe_ok = (ax_e > thr_e) || (ay_e > thr_e);

    // tie goes vertical; zero on the chosen axis reads as up / left
    always_comb
    begin
        if (ax > ay)
            swipe_dir = (!sum_x[ACC_WIDTH-1] && (sum_x != '0)) ? tgc_pkg::DIR_RIGHT
                                                                : tgc_pkg::DIR_LEFT;
        else
            swipe_dir = (!sum_y[ACC_WIDTH-1] && (sum_y != '0)) ? tgc_pkg::DIR_DOWN
                                                                : tgc_pkg::DIR_UP;
    end

    assign dev      = $signed({1'b0, last_scale}) - $signed({1'b0, tgc_pkg::SCALE_ONE});
    assign adev     = dev[DW-1] ? DW'(-dev) : DW'(dev);
    assign pinch_ok = adev > {1'b0, cfg.pinch_thr};

    always_comb
    begin
        if (pinch_end)
        begin
            // a hit implies a nonzero deviation, so the sign alone picks out
            dir = dev[DW-1] ? tgc_pkg::DIR_IN : tgc_pkg::DIR_OUT;
            idx = {2'b10, four, dir[0]};
        end
        else
        begin
            dir = swipe_dir;
            idx = {1'b0, four, swipe_dir};
        end
    end

    assign gesture.hit       = fingers_ok && cfg.enable[idx] &&
                               ((swipe_end && swipe_ok) || (pinch_end && pinch_ok));
    assign gesture.kind      = pinch_end ? tgc_pkg::KIND_PINCH : tgc_pkg::KIND_SWIPE;
    assign gesture.fingers   = held_fingers[tgc_pkg::GFING_W-1:0];
    assign gesture.direction = dir;
    assign gesture.index     = idx;

endmodule

>>> hw/rtl/tgc_checker.sv
// Port-level checker for the touchpad gesture classifier, bound to the top.
// Depends on tgc_pkg and touchpad_gesture_classifier_macros.svh.
`include "touchpad_gesture_classifier_macros.svh"

module tgc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            evt_ready,
    input logic                            g_valid,
    input logic                            g_ready,
    input logic                            g_kind,
    input logic [tgc_pkg::GFING_W-1:0]     g_fingers,
    input logic [tgc_pkg::GDIR_W-1:0]      g_dir,
    input logic [tgc_pkg::GIDX_W-1:0]      g_index
);
    logic four;
    assign four = g_fingers == 3'd4;

    // a stalled word holds
    `TGC_ASSERT_NEXT(a_hold, clk, rst_n, g_valid && !g_ready, g_valid && $stable({g_kind, g_fingers, g_dir, g_index}))
    // finger count is three or four
    `TGC_ASSERT_IMPL(a_fingers, clk, rst_n, g_valid, g_fingers == 3'd3 || g_fingers == 3'd4)
    // index agrees with kind, fingers and direction
    `TGC_ASSERT_IMPL(a_index, clk, rst_n, g_valid, (g_kind == tgc_pkg::KIND_SWIPE) ? (g_index == {1'b0, four, g_dir}) : (g_index == {2'b10, four, g_dir[0]} && !g_dir[1]))
    // an empty output slot never blocks events
    `TGC_ASSERT_IMPL(a_flow, clk, rst_n, !g_valid, evt_ready)

endmodule

bind touchpad_gesture_classifier tgc_checker u_tgc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_ready (evt.ready),
    .g_valid   (gesture.valid),
    .g_ready   (gesture.ready),
    .g_kind    (gesture.gesture_kind),
    .g_fingers (gesture.gesture_fingers),
    .g_dir     (gesture.gesture_direction),
    .g_index   (gesture.gesture_index)
);

>>> tb/sv/touchpad_gesture_classifier_checker.sv
// Gesture predictor and result comparison for the touchpad gesture classifier.
// Watches the event, gesture and register channels. Depends on tgc_pkg and tgc_if.
module touchpad_gesture_classifier_checker #(
    parameter int ACC_WIDTH = tgc_pkg::ACC_WIDTH_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    tgc_event_if   evt,
    tgc_gesture_if gesture,
    tgc_cfg_if     cfg,
    output int     errors,
    output int     pending,
    output int     compared
);
    timeunit 1ns;
    timeprecision 1ps;
    import tgc_pkg::*;

    localparam longint ACC_MAX = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    // shadow copy of the block's state and registers
    logic signed [ACC_WIDTH-1:0] sum_x_q;
    logic signed [ACC_WIDTH-1:0] sum_y_q;
    logic [SCALE_W-1:0]          scale_q;
    logic [FINGER_W-1:0]         fingers_q;
    cfg_t                        regs_q;

    gesture_t pending_gestures[$];

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [DELTA_W-1:0]   delta
    );
        longint r;
        r = longint'(acc) + longint'(delta);
        if (r > ACC_MAX)
            r = ACC_MAX;
        else if (r < ACC_MIN)
            r = ACC_MIN;
        return ACC_WIDTH'(r);
    endfunction

    // builds the word; hit says whether the enable mask lets it out
    function automatic gesture_t make_gesture(
        input logic                kind,
        input logic [FINGER_W-1:0] fingers,
        input logic [GDIR_W-1:0]   dir
    );
        gesture_t g;
        int       f;
        f = int'(fingers) - 3;
        g.kind      = kind;
        g.fingers   = fingers[GFING_W-1:0];
        g.direction = dir;
        if (kind == KIND_SWIPE)
            g.index = GIDX_W'(f * 4 + int'(dir));
        else
            g.index = GIDX_W'(8 + f * 2 + int'(dir));
        g.hit = regs_q.enable[g.index];
        return g;
    endfunction

    function automatic gesture_t classify_event(input event_t ev);
        gesture_t          g;
        longint            ax;
        longint            ay;
        longint            thr;
        int                dev;
        int                adev;
        logic [GDIR_W-1:0] dir;
        g = '0;
        case (ev.func)
            FUNC_SWIPE_BEGIN:
            begin
                sum_x_q   = '0;
                sum_y_q   = '0;
                fingers_q = ev.finger_count;
            end
            FUNC_SWIPE_UPDATE:
            begin
                sum_x_q = sat_add(sum_x_q, ev.delta_x);
                sum_y_q = sat_add(sum_y_q, ev.delta_y);
            end
            FUNC_SWIPE_END:
            begin
                if (fingers_q == FINGERS_THREE || fingers_q == FINGERS_FOUR)
                begin
                    ax  = longint'(sum_x_q);
                    ay  = longint'(sum_y_q);
                    ax  = (ax < 0) ? -ax : ax;
                    ay  = (ay < 0) ? -ay : ay;
                    thr = longint'(regs_q.swipe_thr);
                    if (ax > thr || ay > thr)
                    begin
                        if (ax > ay)
                            dir = (sum_x_q > 0) ? DIR_RIGHT : DIR_LEFT;
                        else
                            dir = (sum_y_q > 0) ? DIR_DOWN : DIR_UP;
                        g = make_gesture(KIND_SWIPE, fingers_q, dir);
                    end
                end
                fingers_q = '0;
            end
            FUNC_PINCH_BEGIN:
            begin
                scale_q   = SCALE_ONE;
                fingers_q = ev.finger_count;
            end
            FUNC_PINCH_UPDATE:
                scale_q = ev.pinch_scale;
            FUNC_PINCH_END:
            begin
                if (fingers_q == FINGERS_THREE || fingers_q == FINGERS_FOUR)
                begin
                    dev  = int'(scale_q) - int'(SCALE_ONE);
                    adev = (dev < 0) ? -dev : dev;
                    if (adev > int'(regs_q.pinch_thr))
                        g = make_gesture(KIND_PINCH, fingers_q, (dev > 0) ? DIR_OUT : DIR_IN);
                end
                fingers_q = '0;
            end
            default:
                ;
        endcase
        return g;
    endfunction

    always @(posedge clk)
    begin : watch
        event_t   ev;
        gesture_t g;
        gesture_t want;
        if (!rst_n)
        begin
            sum_x_q          = '0;
            sum_y_q          = '0;
            scale_q          = SCALE_ONE;
            fingers_q        = '0;
            regs_q.swipe_thr = SWIPE_THR_RST;
            regs_q.pinch_thr = PINCH_THR_RST;
            regs_q.enable    = ENABLE_RST;
            errors           = 0;
            compared         = 0;
            pending_gestures.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SWIPE_THR: regs_q.swipe_thr = cfg.data[SWIPE_THR_W-1:0];
                    REG_PINCH_THR: regs_q.pinch_thr = cfg.data[PINCH_THR_W-1:0];
                    REG_ENABLE:    regs_q.enable    = cfg.data[MASK_W-1:0];
                    default:       ;
                endcase
            end
            if (evt.valid && evt.ready)
            begin
                ev.func         = evt.func;
                ev.finger_count = evt.finger_count;
                ev.delta_x      = evt.delta_x;
                ev.delta_y      = evt.delta_y;
                ev.pinch_scale  = evt.pinch_scale;
                g = classify_event(ev);
                if (g.hit)
                    pending_gestures.push_back(g);
            end
            if (gesture.valid && gesture.ready)
            begin
                if (pending_gestures.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected gesture, expected none, got kind %0d fingers %0d direction %0d index %0d",
                             $time, gesture.gesture_kind, gesture.gesture_fingers,
                             gesture.gesture_direction, gesture.gesture_index);
                end
                else
                begin
                    want = pending_gestures.pop_front();
                    compared++;
                    if (gesture.gesture_kind !== want.kind ||
                        gesture.gesture_fingers !== want.fingers ||
                        gesture.gesture_direction !== want.direction ||
                        gesture.gesture_index !== want.index)
                    begin
                        errors++;
                        $display("%0t: gesture mismatch, expected kind %0d fingers %0d direction %0d index %0d, got kind %0d fingers %0d direction %0d index %0d",
                                 $time, want.kind, want.fingers, want.direction, want.index,
                                 gesture.gesture_kind, gesture.gesture_fingers,
                                 gesture.gesture_direction, gesture.gesture_index);
                    end
                end
            end
        end
        pending = pending_gestures.size();
    end

endmodule

>>> tb/sv/touchpad_gesture_classifier_tb.sv
// Top of the touchpad gesture classifier bench: clock, reset, event and register
// stimulus, back pressure on the gesture side and the verdict.
// Depends on tgc_pkg, tgc_if, the block and touchpad_gesture_classifier_checker.
module touchpad_gesture_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tgc_pkg::*;

    localparam int ACC_W         = ACC_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 4;     // event register plus result register, with margin
    localparam int EVENT_TARGET  = 1100;
    localparam int PHASE_LEN     = 110;   // events between register reloads
    localparam int SAT_RUN       = 272;   // enough full-scale updates to pin a 24-bit sum

    // codes the package leaves unnamed
    localparam logic [FUNC_W-1:0]    FUNC_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0]    FUNC_RSVD_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   compared;
    int   events_sent;
    int   reg_writes;
    int   settings_used;
    bit   tx_burst;       // set for stretches where the sender never idles

    tgc_event_if   evt_ch();
    tgc_gesture_if ges_ch();
    tgc_cfg_if     cfg_ch();

    touchpad_gesture_classifier #(
        .ACC_WIDTH(ACC_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_ch),
        .gesture (ges_ch),
        .cfg     (cfg_ch)
    );

    touchpad_gesture_classifier_checker #(
        .ACC_WIDTH(ACC_W)
    ) gesture_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt_ch),
        .gesture  (ges_ch),
        .cfg      (cfg_ch),
        .errors   (errors),
        .pending  (pending),
        .compared (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // Mostly the finger counts that can classify, sometimes anything.
    function automatic logic [FINGER_W-1:0] pick_fingers();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return FINGERS_THREE;
        if (r < 8)
            return FINGERS_FOUR;
        return FINGER_W'($urandom);
    endfunction

    // mode 0: full range, 1: around the default threshold, 2: tiny
    function automatic logic [DELTA_W-1:0] rand_delta(input int mode);
        case (mode)
            0:       return rnd16();
            1:       return DELTA_W'($urandom_range(0, 3200) - 1600);
            default: return DELTA_W'($urandom_range(0, 200) - 100);
        endcase
    endfunction

    // One event word: random idle first (unless in a burst), then hold valid
    // until the handshake. Valid stays high into the next word when it has no gap.
    task automatic send_event(
        input logic [FUNC_W-1:0]   f,
        input logic [FINGER_W-1:0] fc,
        input logic [DELTA_W-1:0]  dx,
        input logic [DELTA_W-1:0]  dy,
        input logic [SCALE_W-1:0]  sc
    );
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.func         <= f;
        evt_ch.finger_count <= fc;
        evt_ch.delta_x      <= dx;
        evt_ch.delta_y      <= dy;
        evt_ch.pinch_scale  <= sc;
        do @(posedge clk); while (!evt_ch.ready);
        events_sent++;
    endtask

    // Fields an event kind ignores carry random values.
    task automatic swipe_begin(input logic [FINGER_W-1:0] fc);
        send_event(FUNC_SWIPE_BEGIN, fc, rnd16(), rnd16(), rnd16());
    endtask

    task automatic swipe_move(input logic [DELTA_W-1:0] dx, input logic [DELTA_W-1:0] dy);
        send_event(FUNC_SWIPE_UPDATE, FINGER_W'($urandom), dx, dy, rnd16());
    endtask

    task automatic swipe_end();
        send_event(FUNC_SWIPE_END, FINGER_W'($urandom), rnd16(), rnd16(), rnd16());
    endtask

    task automatic pinch_begin(input logic [FINGER_W-1:0] fc);
        send_event(FUNC_PINCH_BEGIN, fc, rnd16(), rnd16(), rnd16());
    endtask

    task automatic pinch_move(input logic [SCALE_W-1:0] sc);
        send_event(FUNC_PINCH_UPDATE, FINGER_W'($urandom), rnd16(), rnd16(), sc);
    endtask

    task automatic pinch_end();
        send_event(FUNC_PINCH_END, FINGER_W'($urandom), rnd16(), rnd16(), rnd16());
    endtask

    // Long run of one extreme update; both sums end pinned at the rails.
    task automatic saturate_swipe(
        input logic [FINGER_W-1:0] fc,
        input logic [DELTA_W-1:0]  dx,
        input logic [DELTA_W-1:0]  dy
    );
        swipe_begin(fc);
        repeat (SAT_RUN) swipe_move(dx, dy);
        swipe_end();
    endtask

    // Stop sending, wait for every predicted gesture, then let the pipe empty
    // of events that gave none. Pending is sampled on the falling edge.
    task automatic wait_idle();
        evt_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg is back to back; the caller lowers valid after the last word
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        reg_writes++;
    endtask

    // Junk in the data bits above each register's width must be dropped.
    task automatic load_settings(
        input logic [SWIPE_THR_W-1:0] sw,
        input logic [PINCH_THR_W-1:0] pn,
        input logic [MASK_W-1:0]      en,
        input bit                     poke_unused
    );
        logic [31:0] r;
        r = $urandom;
        write_reg(REG_SWIPE_THR, sw);
        write_reg(REG_PINCH_THR, {r[3:0], pn});
        write_reg(REG_ENABLE, {r[11:4], en});
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Gesture side: a random stall before each word, with stretches at full rate.
    initial
    begin : gesture_sink
        int  stall;
        int  taken;
        bit  rx_burst;
        ges_ch.ready = 1'b0;
        taken        = 0;
        rx_burst     = 1'b0;
        forever
        begin
            if (taken % 30 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                ges_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            ges_ch.ready <= 1'b1;
            do @(posedge clk); while (!ges_ch.valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int phase;
        int next_phase_at;
        int pick;
        int mode;
        int count;
        logic [31:0] r;

        rst_n               = 1'b0;
        evt_ch.valid        = 1'b0;
        evt_ch.func         = FUNC_SWIPE_BEGIN;
        evt_ch.finger_count = '0;
        evt_ch.delta_x      = '0;
        evt_ch.delta_y      = '0;
        evt_ch.pinch_scale  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_SWIPE_THR;
        cfg_ch.data         = '0;
        events_sent         = 0;
        reg_writes          = 0;
        settings_used       = 1;
        tx_burst            = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, reset register values (640 / 614 / all enabled) ----
        // full-scale right swipe, three fingers
        swipe_begin(FINGERS_THREE);
        swipe_move(16'h7FFF, 16'd100);
        swipe_end();
        // full-scale left
        swipe_begin(FINGERS_THREE);
        swipe_move(16'h8000, 16'd5);
        swipe_end();
        // motion exactly at threshold: not strictly above, nothing out
        swipe_begin(FINGERS_FOUR);
        swipe_move(16'd0, DELTA_W'(-640));
        swipe_end();
        // equal magnitudes on both axes: vertical wins, positive is down
        swipe_begin(FINGERS_THREE);
        swipe_move(DELTA_W'(-700), DELTA_W'(700));
        swipe_end();
        // scale at zero: pinch in
        pinch_begin(FINGERS_THREE);
        pinch_move(16'h0000);
        pinch_end();
        // scale at max: pinch out, four fingers
        pinch_begin(FINGERS_FOUR);
        pinch_move(16'hFFFF);
        pinch_end();
        // deviation exactly at threshold: nothing
        pinch_begin(FINGERS_THREE);
        pinch_move(SCALE_ONE + 16'd614);
        pinch_end();
        // bad finger count kills the gesture
        swipe_begin(4'd15);
        swipe_end();
        // shared finger count: pinch begin re-latches it, swipe end uses the sums
        swipe_begin(4'd0);
        swipe_move(16'd2000, 16'd0);
        pinch_begin(FINGERS_FOUR);
        swipe_end();
        // the end above cleared the count, so this end is silent
        pinch_end();
        // unused event codes do nothing
        send_event(FUNC_RSVD_6, FINGER_W'($urandom), rnd16(), rnd16(), rnd16());
        send_event(FUNC_RSVD_7, FINGER_W'($urandom), rnd16(), rnd16(), rnd16());
        wait_idle();

        // ---- random part, register settings rotate every PHASE_LEN events ----
        phase         = 0;
        next_phase_at = 0;
        while (events_sent < EVENT_TARGET)
        begin
            if (events_sent >= next_phase_at)
            begin
                // sender holds off here until the gesture side has drained
                wait_idle();
                r = $urandom;
                case (phase % 5)
                    0: load_settings('0, '0, '1, 1'b0);
                    1: load_settings('1, '1, '0, 1'b0);
                    2: load_settings(SWIPE_THR_W'($urandom_range(0, 3000)),
                                     PINCH_THR_W'($urandom_range(0, 1200)), MASK_W'(r), 1'b1);
                    3: load_settings(SWIPE_THR_RST, PINCH_THR_RST, ENABLE_RST, 1'b0);
                    default: load_settings(SWIPE_THR_W'($urandom), PINCH_THR_W'($urandom),
                                           MASK_W'(r), 1'b0);
                endcase
                if (phase == 0)
                begin
                    // both rails: ties at the top go down; min beats max in
                    // magnitude by one, so that one goes left
                    saturate_swipe(FINGERS_FOUR, 16'h7FFF, 16'h7FFF);
                    saturate_swipe(FINGERS_THREE, 16'h8000, 16'h7FFF);
                end
                phase++;
                next_phase_at = events_sent + PHASE_LEN;
            end

            tx_burst = ($urandom_range(0, 4) == 0);
            pick     = $urandom_range(0, 19);
            if (pick < 9)
            begin
                // swipe; now and then a long one
                swipe_begin(pick_fingers());
                count = (pick == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
                mode  = $urandom_range(0, 2);
                repeat (count) swipe_move(rand_delta(mode), rand_delta(mode));
                if ($urandom_range(0, 9) != 0)
                    swipe_end();
            end
            else if (pick < 15)
            begin
                pinch_begin(pick_fingers());
                mode = $urandom_range(0, 1);
                repeat ($urandom_range(0, 4))
                    pinch_move(mode ? rnd16() : SCALE_W'(4096 + $urandom_range(0, 1600) - 800));
                if ($urandom_range(0, 9) != 0)
                    pinch_end();
            end
            else if (pick < 18)
            begin
                // broken sequences: the other kind's end, or an end with no begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        swipe_begin(pick_fingers());
                        swipe_move(rand_delta(1), rand_delta(1));
                        pinch_end();
                    end
                    1:
                    begin
                        pinch_begin(pick_fingers());
                        pinch_move(rnd16());
                        swipe_end();
                    end
                    default:
                    begin
                        if ($urandom_range(0, 1) != 0)
                            swipe_end();
                        else
                            pinch_end();
                    end
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_event(FUNC_W'($urandom), FINGER_W'($urandom),
                               rnd16(), rnd16(), rnd16());
            end
        end

        wait_idle();
        $display("Summary: %0d events driven, %0d register writes across %0d settings,",
                 events_sent, reg_writes, settings_used);
        $display("         %0d gestures compared, %0d still outstanding", compared, pending);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
